// ----- rtl/ala_pkg.sv -----
// Shared types and constants of the address lease allocator.
`default_nettype none
package ala_pkg;
	localparam int POOL_DEPTH = 1024;
	localparam int IDX_BITS   = $clog2(POOL_DEPTH);
	localparam int SIZE_BITS  = 11;
	localparam int HOST_BITS  = 16;
	localparam int TIME_BITS  = 40;
	localparam int ADDR_BITS  = 16;
	localparam int PADDR_BITS = 6;
	localparam int PDATA_BITS = 64;

	localparam logic [1:0] CMD_DISCOVER = 2'd0;
	localparam logic [1:0] CMD_REQUEST  = 2'd1;

	localparam logic [1:0] REPLY_OFFER = 2'd0;
	localparam logic [1:0] REPLY_ACK   = 2'd1;
	localparam logic [1:0] REPLY_NAK   = 2'd2;

	localparam logic [2:0] REG_POOL_SIZE     = 3'd0;
	localparam logic [2:0] REG_DEFAULT_LEASE = 3'd1;
	localparam logic [2:0] REG_MAX_LEASE     = 3'd2;
	localparam logic [2:0] REG_MIN_LEASE     = 3'd3;
	localparam logic [2:0] REG_SERVER_ID     = 3'd4;

	typedef enum logic [1:0] {
		ST_FREE     = 2'd0,
		ST_PENDING  = 2'd1,
		ST_OCCUPIED = 2'd2,
		ST_EXPIRED  = 2'd3
	} entry_status_t;

	typedef struct packed {
		entry_status_t          status;
		logic [TIME_BITS-1:0]   expiry;
		logic [HOST_BITS-1:0]   owner;
	} entry_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;
endpackage
`default_nettype wire

// ----- rtl/ala_ram.sv -----
// Lease table memory: one write port, one registered read port.
`default_nettype none
module ala_ram (
	input  wire logic                    clk,
	input  wire logic                    we,
	input  wire logic [ala_pkg::IDX_BITS-1:0] waddr,
	input  wire ala_pkg::entry_t         wdata,
	input  wire logic                    re,
	input  wire logic [ala_pkg::IDX_BITS-1:0] raddr,
	output ala_pkg::entry_t              rdata
);
	import ala_pkg::*;

	entry_t mem [POOL_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/address_lease_allocator.sv -----
// Top level of the address lease allocator: control, scan and registers.
`default_nettype none
// Usage:
//  - Messages enter on the command port: an item is taken at a clock edge
//    with start high and busy low. Fields: command, now, sender_id,
//    receiver_id, to_all, requested_address, requested_expiry.
//  - A message gives zero or one reply (offer, ack or nak). The reply sits
//    on reply_kind/client_id/address/expiry for exactly one cycle, marked
//    by done. The receiver cannot stall; every reply is taken.
//  - Each message passes from accept to reply through the prep state, a
//    read-modify-write pass over the pool in use (pool_size, capped at
//    1024; one entry per cycle through the single read port of the table
//    RAM), the drain state and the finish state, which writes the chosen
//    entry and launches the reply, where there is one. An empty pool skips
//    the pass. busy is low again the cycle the reply is shown.
//  - The pass ages every entry and, on the same visit, looks for the
//    sender's entry, the first free and the first expired entry.
//  - Configuration goes through the APB port, 64-bit data, register i at
//    byte address 8*i. Write only while idle.
//  - After reset the table is cleared by a pass over all 1024 entries, one
//    entry per cycle; busy stays high until it ends. Register writes are taken
//    during that pass.
module address_lease_allocator (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// command channel
	input  wire logic                             start,
	output      logic                             busy,
	input  wire logic [1:0]                       command,
	input  wire logic [ala_pkg::TIME_BITS-1:0]    now,
	input  wire logic [ala_pkg::HOST_BITS-1:0]    sender_id,
	input  wire logic [ala_pkg::HOST_BITS-1:0]    receiver_id,
	input  wire logic                             to_all,
	input  wire logic [ala_pkg::ADDR_BITS-1:0]    requested_address,
	input  wire logic [ala_pkg::TIME_BITS-1:0]    requested_expiry,
	// result channel
	output      logic                             done,
	output      logic [1:0]                       reply_kind,
	output      logic [ala_pkg::HOST_BITS-1:0]    client_id,
	output      logic [ala_pkg::ADDR_BITS-1:0]    address,
	output      logic [ala_pkg::TIME_BITS-1:0]    expiry,
	// configuration
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [ala_pkg::PADDR_BITS-1:0]   paddr,
	input  wire logic [ala_pkg::PDATA_BITS-1:0]   pwdata,
	output      logic [ala_pkg::PDATA_BITS-1:0]   prdata,
	output      logic                             pready
);
	import ala_pkg::*;

	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	// configuration registers
	logic [SIZE_BITS-1:0] pool_size_q;
	logic [TIME_BITS-1:0] default_lease_q, max_lease_q, min_lease_q;
	logic [HOST_BITS-1:0] server_id_q;

	// held message
	logic [1:0]           cmd_q;
	logic [TIME_BITS-1:0] now_q, want_q;
	logic [HOST_BITS-1:0] who_q, dest_q;
	logic                 to_all_q;
	logic [ADDR_BITS-1:0] addr_q;

	// lease bounds for this message
	logic [TIME_BITS-1:0] lo_q, hi_q, def_q;

	state_t state_q, state_nx;
	logic [IDX_BITS-1:0] clr_idx_q, rd_idx_q;
	logic [IDX_BITS-1:0] idx_s1;
	logic                vld_s1;

	// search results
	logic                own_hit_q, free_hit_q, exp_hit_q, match_q;
	logic [IDX_BITS-1:0] own_idx_q, free_idx_q, exp_idx_q;

	// result registers
	logic                 done_q;
	logic [1:0]           kind_q;
	logic [HOST_BITS-1:0] client_q;
	logic [ADDR_BITS-1:0] address_q;
	logic [TIME_BITS-1:0] expiry_q;

	// RAM ports
	logic   ram_we, ram_re;
	logic [IDX_BITS-1:0] ram_waddr, ram_raddr;
	entry_t ram_wdata, ram_rdata;

	ala_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// pool in use, capped at the table depth
	logic [SIZE_BITS-1:0] n_use;
	assign n_use = (pool_size_q > SIZE_BITS'(POOL_DEPTH)) ? SIZE_BITS'(POOL_DEPTH)
		: pool_size_q;

	logic [SIZE_BITS-1:0] last_idx;
	assign last_idx = n_use - SIZE_BITS'(1);

	// message classes
	logic is_disc, is_req, req_this, req_other;
	assign is_disc   = (cmd_q == CMD_DISCOVER) && to_all_q;
	assign is_req    = (cmd_q == CMD_REQUEST) && !to_all_q;
	assign req_this  = is_req && (dest_q == server_id_q);
	assign req_other = is_req && (dest_q != server_id_q);

	// APB
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[5:3])
			REG_POOL_SIZE:     prdata = PDATA_BITS'(pool_size_q);
			REG_DEFAULT_LEASE: prdata = PDATA_BITS'(default_lease_q);
			REG_MAX_LEASE:     prdata = PDATA_BITS'(max_lease_q);
			REG_MIN_LEASE:     prdata = PDATA_BITS'(min_lease_q);
			REG_SERVER_ID:     prdata = PDATA_BITS'(server_id_q);
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q     <= SIZE_BITS'(POOL_DEPTH);
			default_lease_q <= '0;
			max_lease_q     <= '0;
			min_lease_q     <= '0;
			server_id_q     <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[5:3])
				REG_POOL_SIZE:     pool_size_q     <= pwdata[SIZE_BITS-1:0];
				REG_DEFAULT_LEASE: default_lease_q <= pwdata[TIME_BITS-1:0];
				REG_MAX_LEASE:     max_lease_q     <= pwdata[TIME_BITS-1:0];
				REG_MIN_LEASE:     min_lease_q     <= pwdata[TIME_BITS-1:0];
				REG_SERVER_ID:     server_id_q     <= pwdata[HOST_BITS-1:0];
				default: ;
			endcase
		end
	end

	// saturating time sums
	logic [TIME_BITS:0] sum_lo, sum_hi, sum_def;
	assign sum_lo  = {1'b0, now_q} + {1'b0, min_lease_q};
	assign sum_hi  = {1'b0, now_q} + {1'b0, max_lease_q};
	assign sum_def = {1'b0, now_q} + {1'b0, default_lease_q};

	// chosen expiry from the registered bounds
	logic [TIME_BITS-1:0] chosen;
	always_comb begin
		priority if (want_q == '0) begin
			chosen = def_q;
		end else if (want_q < lo_q) begin
			chosen = lo_q;
		end else if (want_q > hi_q) begin
			chosen = hi_q;
		end else begin
			chosen = want_q;
		end
	end

	// aging and cancel of the entry read last cycle
	entry_t swept;
	always_comb begin
		swept = ram_rdata;
		if (ram_rdata.status == ST_PENDING && now_q >= ram_rdata.expiry) begin
			swept = '{status: ST_FREE, expiry: '0, owner: '0};
		end else if (ram_rdata.status == ST_OCCUPIED && now_q >= ram_rdata.expiry) begin
			swept.status = ST_EXPIRED;
			swept.expiry = '0;
		end
		if (req_other && who_q != '0 && swept.status == ST_PENDING
				&& swept.owner == who_q) begin
			swept = '{status: ST_FREE, expiry: '0, owner: '0};
		end
	end

	// request address check
	logic                addr_ok;
	logic [IDX_BITS-1:0] addr_idx;
	assign addr_ok  = (addr_q != '0) && (addr_q <= ADDR_BITS'(n_use));
	assign addr_idx = IDX_BITS'(addr_q - ADDR_BITS'(1));

	logic                any_hit;
	logic [IDX_BITS-1:0] pick_idx;
	logic                grant;
	assign any_hit  = own_hit_q || free_hit_q || exp_hit_q;
	assign pick_idx = own_hit_q ? own_idx_q : (free_hit_q ? free_idx_q : exp_idx_q);
	assign grant    = addr_ok && (who_q != '0) && match_q;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_idx_q == IDX_BITS'(POOL_DEPTH - 1)) state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_nx = S_PREP;
			end
			S_PREP: begin
				state_nx = (n_use == '0) ? S_FINISH : S_SCAN;
			end
			S_SCAN: begin
				if ({1'b0, rd_idx_q} == last_idx) state_nx = S_DRAIN;
			end
			S_DRAIN:  state_nx = S_FINISH;
			S_FINISH: state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	// RAM controls
	always_comb begin
		ram_re    = (state_q == S_SCAN);
		ram_raddr = rd_idx_q;
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = swept;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
				ram_wdata = '{status: ST_FREE, expiry: '0, owner: '0};
			end
			S_FINISH: begin
				ram_waddr = is_disc ? pick_idx : addr_idx;
				ram_we    = (is_disc && any_hit) || (req_this && grant);
				ram_wdata = is_disc ? '{status: ST_PENDING, expiry: chosen, owner: who_q}
					: '{status: ST_OCCUPIED, expiry: chosen, owner: who_q};
			end
			default: begin
				ram_we = vld_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_idx_q <= '0;
			vld_s1    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			vld_s1  <= (state_q == S_SCAN);
			done_q  <= (state_q == S_FINISH) && ((is_disc && any_hit) || req_this);
			if (state_q == S_CLEAR) clr_idx_q <= clr_idx_q + IDX_BITS'(1);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (state_q == S_IDLE && start) begin
			cmd_q    <= command;
			now_q    <= now;
			who_q    <= sender_id;
			dest_q   <= receiver_id;
			to_all_q <= to_all;
			addr_q   <= requested_address;
			want_q   <= requested_expiry;
		end
		if (state_q == S_PREP) begin
			lo_q       <= sum_lo[TIME_BITS] ? TIME_MAX : sum_lo[TIME_BITS-1:0];
			hi_q       <= sum_hi[TIME_BITS] ? TIME_MAX : sum_hi[TIME_BITS-1:0];
			def_q      <= sum_def[TIME_BITS] ? TIME_MAX : sum_def[TIME_BITS-1:0];
			rd_idx_q   <= '0;
			own_hit_q  <= 1'b0;
			free_hit_q <= 1'b0;
			exp_hit_q  <= 1'b0;
			match_q    <= 1'b0;
		end
		if (state_q == S_SCAN) rd_idx_q <= rd_idx_q + IDX_BITS'(1);
		if (vld_s1) begin
			if (!own_hit_q && who_q != '0 && swept.owner == who_q) begin
				own_hit_q <= 1'b1;
				own_idx_q <= idx_s1;
			end
			if (!free_hit_q && swept.status == ST_FREE) begin
				free_hit_q <= 1'b1;
				free_idx_q <= idx_s1;
			end
			if (!exp_hit_q && swept.status == ST_EXPIRED) begin
				exp_hit_q <= 1'b1;
				exp_idx_q <= idx_s1;
			end
			if (addr_ok && idx_s1 == addr_idx) match_q <= (swept.owner == who_q);
		end
		if (state_q == S_FINISH) begin
			client_q <= who_q;
			if (is_disc) begin
				kind_q    <= REPLY_OFFER;
				address_q <= ADDR_BITS'(pick_idx) + ADDR_BITS'(1);
				expiry_q  <= chosen;
			end else begin
				kind_q    <= grant ? REPLY_ACK : REPLY_NAK;
				address_q <= addr_q;
				expiry_q  <= grant ? chosen : '0;
			end
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign reply_kind = kind_q;
	assign client_id  = client_q;
	assign address    = address_q;
	assign expiry     = expiry_q;
endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the address lease allocator.
`timescale 1ns / 100ps
module testbench;
	import ala_pkg::*;

	localparam logic [1:0] CMD_OTHER = 2'd2;
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam logic [63:0] TIME_MAX = (64'd1 << TIME_BITS) - 1;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [1:0]           cmd;
		logic [TIME_BITS-1:0] at;
		logic [HOST_BITS-1:0] snd;
		logic [HOST_BITS-1:0] rcv;
		logic                 all;
		logic [ADDR_BITS-1:0] ra;
		logic [TIME_BITS-1:0] want;
	} message_t;

	typedef struct {
		logic [1:0]           kind;
		logic [HOST_BITS-1:0] client;
		logic [ADDR_BITS-1:0] addr;
		logic [TIME_BITS-1:0] exp;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] command = '0;
	logic [TIME_BITS-1:0] now = '0;
	logic [HOST_BITS-1:0] sender_id = '0;
	logic [HOST_BITS-1:0] receiver_id = '0;
	logic to_all = 1'b0;
	logic [ADDR_BITS-1:0] requested_address = '0;
	logic [TIME_BITS-1:0] requested_expiry = '0;
	logic done;
	logic [1:0] reply_kind;
	logic [HOST_BITS-1:0] client_id;
	logic [ADDR_BITS-1:0] address;
	logic [TIME_BITS-1:0] expiry;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_BITS-1:0] paddr = '0;
	logic [PDATA_BITS-1:0] pwdata = '0;
	logic [PDATA_BITS-1:0] prdata;
	logic pready;

	address_lease_allocator dut (.*);

	always #10 clk = ~clk;

	// shadow of the lease table and the registers
	entry_status_t lease_status [POOL_DEPTH];
	logic [63:0] lease_expiry [POOL_DEPTH];
	logic [15:0] lease_owner [POOL_DEPTH];
	logic [63:0] cfg_pool = 1024, cfg_default = 0, cfg_max = 0, cfg_min = 0, cfg_server = 0;

	message_t pending_msgs[$];
	reply_t expected_replies[$];
	message_t cur;
	logic took = 1'b0;
	logic idle_on = 1'b1;
	int gap = 0;
	int errors = 0;
	int stall_cnt = 0;
	int n_msgs = 0, n_offer = 0, n_ack = 0, n_nak = 0;
	logic [63:0] clock_now = 0;

	function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
		return (b > TIME_MAX - a) ? TIME_MAX : a + b;
	endfunction

	function automatic logic [63:0] lease_end(logic [63:0] want, logic [63:0] t);
		logic [63:0] lo, hi;
		lo = sat_sum(t, cfg_min);
		hi = sat_sum(t, cfg_max);
		if (want == 0) return sat_sum(t, cfg_default);
		if (want < lo) return lo;
		if (want > hi) return hi;
		return want;
	endfunction

	function automatic void release_lease(int k);
		lease_status[k] = ST_FREE;
		lease_owner[k] = '0;
		lease_expiry[k] = '0;
	endfunction

	// Age the table, then apply one message; queue any reply it gives.
	function automatic void predict_reply(message_t m);
		int n, k, pick;
		reply_t r;
		n = (cfg_pool > POOL_DEPTH) ? POOL_DEPTH : int'(cfg_pool);
		for (k = 0; k < n; k++) begin
			if (lease_status[k] == ST_PENDING && m.at >= lease_expiry[k]) begin
				release_lease(k);
			end else if (lease_status[k] == ST_OCCUPIED && m.at >= lease_expiry[k]) begin
				lease_status[k] = ST_EXPIRED;
				lease_expiry[k] = '0;
			end
		end
		if (m.cmd == CMD_DISCOVER && m.all) begin
			pick = -1;
			if (m.snd != 0)
				for (k = 0; k < n && pick < 0; k++)
					if (lease_owner[k] == m.snd) pick = k;
			for (k = 0; k < n && pick < 0; k++)
				if (lease_status[k] == ST_FREE) pick = k;
			for (k = 0; k < n && pick < 0; k++)
				if (lease_status[k] == ST_EXPIRED) pick = k;
			if (pick < 0) return;
			lease_status[pick] = ST_PENDING;
			lease_owner[pick] = m.snd;
			lease_expiry[pick] = lease_end(64'(m.want), 64'(m.at));
			r.kind = REPLY_OFFER;
			r.client = m.snd;
			r.addr = ADDR_BITS'(pick + 1);
			r.exp = lease_expiry[pick][TIME_BITS-1:0];
			expected_replies.push_back(r);
		end else if (m.cmd == CMD_REQUEST && !m.all) begin
			if (m.rcv != cfg_server[HOST_BITS-1:0]) begin
				// declined in favor of another server: drop the sender's holds
				if (m.snd != 0)
					for (k = 0; k < n; k++)
						if (lease_status[k] == ST_PENDING && lease_owner[k] == m.snd)
							release_lease(k);
				return;
			end
			r.client = m.snd;
			r.addr = m.ra;
			if (m.ra >= 1 && m.ra <= n && m.snd != 0 && lease_owner[m.ra-1] == m.snd) begin
				lease_status[m.ra-1] = ST_OCCUPIED;
				lease_expiry[m.ra-1] = lease_end(64'(m.want), 64'(m.at));
				r.kind = REPLY_ACK;
				r.exp = lease_expiry[m.ra-1][TIME_BITS-1:0];
			end else begin
				r.kind = REPLY_NAK;
				r.exp = '0;
			end
			expected_replies.push_back(r);
		end
	endfunction

	// Feed messages: change inputs at the falling edge, hold while busy.
	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (gap > 0) begin
				start <= 1'b0;
				gap = gap - 1;
			end else if (pending_msgs.size() > 0) begin
				cur = pending_msgs.pop_front();
				command <= cur.cmd;
				now <= cur.at;
				sender_id <= cur.snd;
				receiver_id <= cur.rcv;
				to_all <= cur.all;
				requested_address <= cur.ra;
				requested_expiry <= cur.want;
				start <= 1'b1;
				if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 17);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Sample at the rising edge: predict on accept, check each reply.
	always @(posedge clk) begin
		reply_t e;
		message_t m;
		took <= start && !busy;
		if (arst_n) begin
			stall_cnt = stall_cnt + 1;
			if (start && !busy) begin
				m.cmd = command; m.at = now; m.snd = sender_id; m.rcv = receiver_id;
				m.all = to_all; m.ra = requested_address; m.want = requested_expiry;
				predict_reply(m);
				n_msgs++;
				stall_cnt = 0;
			end
			if (done) begin
				stall_cnt = 0;
				if (expected_replies.size() == 0) begin
					$display("%0t: reply with none expected: kind %0d client %0h addr %0h exp %0h",
						$time, reply_kind, client_id, address, expiry);
					errors++;
				end else begin
					e = expected_replies.pop_front();
					case (e.kind)
						REPLY_OFFER: n_offer++;
						REPLY_ACK: n_ack++;
						default: n_nak++;
					endcase
					if (reply_kind !== e.kind) begin
						$display("%0t: reply_kind expected %0d actual %0d", $time, e.kind, reply_kind);
						errors++;
					end
					if (client_id !== e.client) begin
						$display("%0t: client_id expected %0h actual %0h", $time, e.client, client_id);
						errors++;
					end
					if (address !== e.addr) begin
						$display("%0t: address expected %0h actual %0h", $time, e.addr, address);
						errors++;
					end
					if (expiry !== e.exp) begin
						$display("%0t: expiry expected %0h actual %0h", $time, e.exp, expiry);
						errors++;
					end
				end
			end
			if (stall_cnt >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Two-phase register write; the register takes the value at the access edge.
	task automatic write_reg(logic [2:0] idx, logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 3'b000}; pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		stall_cnt = 0;
		case (idx)
			REG_POOL_SIZE: cfg_pool = value & 64'h7FF;
			REG_DEFAULT_LEASE: cfg_default = value & TIME_MAX;
			REG_MAX_LEASE: cfg_max = value & TIME_MAX;
			REG_MIN_LEASE: cfg_min = value & TIME_MAX;
			default: cfg_server = value & 64'hFFFF;
		endcase
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic configure(logic [63:0] pool, logic [63:0] dflt, logic [63:0] mx,
			logic [63:0] mn, logic [63:0] srv);
		write_reg(REG_POOL_SIZE, pool);
		write_reg(REG_DEFAULT_LEASE, dflt);
		write_reg(REG_MAX_LEASE, mx);
		write_reg(REG_MIN_LEASE, mn);
		write_reg(REG_SERVER_ID, srv);
	endtask

	task automatic queue_msg(logic [1:0] cmd, logic [15:0] snd, logic [15:0] rcv,
			logic all, logic [15:0] ra, logic [63:0] want, logic [63:0] step);
		message_t m;
		clock_now = sat_sum(clock_now, step);
		m.cmd = cmd; m.at = clock_now[TIME_BITS-1:0]; m.snd = snd; m.rcv = rcv;
		m.all = all; m.ra = ra; m.want = want[TIME_BITS-1:0];
		pending_msgs.push_back(m);
	endtask

	// Wait until every message is in and answered, plus one pass of slack.
	task automatic settle();
		wait (pending_msgs.size() == 0 && !start);
		wait (expected_replies.size() == 0);
		repeat (POOL_DEPTH + 16) @(posedge clk);
		stall_cnt = 0;
		wait (!busy);
	endtask

	// Mostly discover/request exchanges among a few clients, some declines, some noise.
	task automatic queue_random(int count, int pool);
		int sel;
		logic [63:0] want;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			want = ($urandom_range(0, 3) == 0) ? 0 : clock_now + $urandom_range(0, 3000);
			if (sel < 40)
				queue_msg(CMD_DISCOVER, 16'($urandom_range(1, 8)), 16'($urandom), 1'b1,
					16'($urandom), want, 64'($urandom_range(0, 300)));
			else if (sel < 75)
				queue_msg(CMD_REQUEST, 16'($urandom_range(1, 8)), cfg_server[15:0], 1'b0,
					16'($urandom_range(0, pool + 1)), want, 64'($urandom_range(0, 300)));
			else if (sel < 85)
				queue_msg(CMD_REQUEST, 16'($urandom_range(1, 8)), cfg_server[15:0] ^ 16'h1,
					1'b0, 16'($urandom_range(1, pool)), want, 64'($urandom_range(0, 300)));
			else
				queue_msg(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
					1'($urandom_range(0, 1)), 16'($urandom), {$urandom, $urandom},
					64'($urandom_range(0, 5000)));
		end
	endtask

	initial begin
		int pool;
		for (int k = 0; k < POOL_DEPTH; k++) release_lease(k);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// hold off until the clearing pass after reset is over
		@(posedge clk);
		wait (!busy);

		// directed: four addresses, tight lease bounds
		configure(4, 100, 1000, 10, 5);
		queue_msg(CMD_DISCOVER, 1, 0, 1'b1, 0, 0, 0);            // default lease
		queue_msg(CMD_REQUEST, 1, 5, 1'b0, 1, 0, 1);             // ack
		queue_msg(CMD_REQUEST, 2, 5, 1'b0, 1, 500, 1);           // wrong owner: nak
		queue_msg(CMD_REQUEST, 1, 5, 1'b0, 0, 0, 1);             // address zero
		queue_msg(CMD_REQUEST, 1, 5, 1'b0, 16'hFFFF, 0, 1);      // beyond pool
		queue_msg(CMD_DISCOVER, 2, 0, 1'b1, 0, 1, 1);            // below min
		queue_msg(CMD_DISCOVER, 3, 0, 1'b1, 0, 64'hFF_FFFF_FFFF, 1); // above max
		queue_msg(CMD_DISCOVER, 4, 0, 1'b1, 0, 50, 1);
		queue_msg(CMD_DISCOVER, 6, 0, 1'b1, 0, 0, 1);            // table full: silent
		queue_msg(CMD_REQUEST, 2, 7, 1'b0, 2, 0, 1);             // declined: frees hold
		queue_msg(CMD_DISCOVER, 6, 0, 1'b1, 0, 0, 1);            // takes freed entry
		queue_msg(CMD_DISCOVER, 3, 0, 1'b1, 0, 0, 1);            // own entry again
		queue_msg(CMD_OTHER, 9, 5, 1'b0, 1, 0, 1);
		queue_msg(CMD_SPARE, 9, 5, 1'b1, 1, 0, 1);
		queue_msg(CMD_DISCOVER, 7, 5, 1'b0, 0, 0, 1);            // discover not broadcast
		queue_msg(CMD_REQUEST, 1, 5, 1'b1, 1, 0, 1);             // request broadcast
		queue_msg(CMD_DISCOVER, 0, 0, 1'b1, 0, 0, 1);            // ownerless sender
		queue_msg(CMD_REQUEST, 0, 5, 1'b0, 1, 0, 1);
		queue_msg(CMD_OTHER, 0, 0, 1'b0, 0, 0, 2000);            // holds lapse, lease expires
		queue_msg(CMD_DISCOVER, 8, 0, 1'b1, 0, 0, 1);            // free first
		queue_msg(CMD_DISCOVER, 9, 0, 1'b1, 0, 0, 1);
		queue_msg(CMD_DISCOVER, 10, 0, 1'b1, 0, 0, 1);
		queue_msg(CMD_DISCOVER, 11, 0, 1'b1, 0, 0, 1);           // expired entry reused
		settle();

		// register extremes: empty table, oversize pool, saturating leases
		configure(0, 64'hFF_FFFF_FFFF, 64'hFF_FFFF_FFFF, 0, 16'hFFFF);
		queue_random(5, 2);
		settle();
		configure(2047, 0, 0, 64'hFF_FFFF_FFFF, 0);
		queue_random(4, 8);
		settle();
		configure(1024, 500, 2000, 20, 16'hA5A5);
		queue_random(4, 8);
		settle();

		for (int p = 0; p < 8; p++) begin
			pool = $urandom_range(1, 12);
			configure(64'(pool), 64'($urandom_range(0, 1500)), 64'($urandom_range(0, 3000)),
				64'($urandom_range(0, 200)), 64'($urandom));
			queue_random(18, pool);
			settle();
		end

		// last stretch: no idling, times close to the top of the range
		idle_on = 1'b0;
		gap = 0;
		clock_now = TIME_MAX - 64'd20000;
		configure(6, 64'hFF_FFFF_FFFF, 64'h80_0000_0000, 300, 16'h5A5A);
		queue_random(15, 6);
		settle();

		$display("Covered %0d messages: %0d offers, %0d acks, %0d naks checked,",
			n_msgs, n_offer, n_ack, n_nak);
		$display("over directed cases, register extremes, %0d random pool settings", 8);
		$display("and a back-to-back stretch near the end of the time range.");
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
